/* hw/rtl/ilms_pkg.sv */
// Shared types and constants of the integer list merge sorter.
// Used by every module of the block and by its port checker; depends on nothing.
package ilms_pkg;

	localparam int KEY_WIDTH = 31;
	localparam int MAX_KEYS = 64;
	localparam int ADDR_W = $clog2(MAX_KEYS);
	localparam int CNT_W = $clog2(MAX_KEYS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic last_item;
	} item_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] sorted_key;
		logic last_result;
		logic overflow;
	} result_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} queue_head_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RUN_INIT,
		ST_MERGE_RD,
		ST_MERGE_WR,
		ST_OUT_RD,
		ST_OUT_PUT
	} back_state_t;

endpackage

/* hw/rtl/ilms_front.sv */
// Input side of the sorter: accepts items and holds them in a short queue.
// Depends on ilms_pkg; feeds the queue head to ilms_back.
module ilms_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  ilms_pkg::item_t      item,
	output ilms_pkg::queue_head_t head,
	input  logic                 pop
);

	ilms_pkg::item_t q_mem_q [ilms_pkg::QUEUE_DEPTH];
	logic [ilms_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ilms_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ilms_pkg::QCNT_W-1:0] count_q;
	logic push;
	logic take;

	assign item_stall = (count_q == ilms_pkg::QCNT_W'(ilms_pkg::QUEUE_DEPTH));
	assign push = item_valid && !item_stall;
	assign take = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

endmodule

/* hw/rtl/ilms_back.sv */
// Sorting side: stores keys, runs bottom-up two-way merge passes between two
// memories, then streams the sorted keys into a result register. Depends on ilms_pkg.
module ilms_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ilms_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output ilms_pkg::result_t     result
);

	localparam int CW = ilms_pkg::CNT_W;
	localparam int AW = ilms_pkg::ADDR_W;
	localparam int KW = ilms_pkg::KEY_WIDTH;

	ilms_pkg::back_state_t state_q, state_d;

	logic [KW-1:0] mem0 [ilms_pkg::MAX_KEYS];
	logic [KW-1:0] mem1 [ilms_pkg::MAX_KEYS];
	logic [KW-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	logic [CW-1:0] cnt_q, w_q, lo_q, a_q, b_q, p_q, idx_q;
	logic drop_q, par_q;
	logic out_valid_q;
	ilms_pkg::result_t out_q;

	logic [CW:0] sum_mid, sum_hi;
	logic [CW-1:0] mid, hi, w_next;
	logic [KW-1:0] da, db;
	logic take_b, run_end, pass_end, sort_done;
	logic not_full, load_wr, out_load, out_last;
	logic [AW-1:0] ra, rb, waddr;
	logic [KW-1:0] wdata;
	logic we0, we1;

	assign sum_mid = {1'b0, lo_q} + {1'b0, w_q};
	assign sum_hi = sum_mid + {1'b0, w_q};
	assign mid = (sum_mid > {1'b0, cnt_q}) ? cnt_q : sum_mid[CW-1:0];
	assign hi = (sum_hi > {1'b0, cnt_q}) ? cnt_q : sum_hi[CW-1:0];
	assign w_next = {w_q[CW-2:0], 1'b0};

	assign da = par_q ? rd1a_q : rd0a_q;
	assign db = par_q ? rd1b_q : rd0b_q;
	assign take_b = (a_q >= mid) || ((b_q < hi) && (db < da));
	assign run_end = (p_q + 1'b1 == hi);
	assign pass_end = run_end && (hi == cnt_q);
	assign sort_done = pass_end && (w_next >= cnt_q);

	assign not_full = (cnt_q < CW'(ilms_pkg::MAX_KEYS));
	assign load_wr = (state_q == ilms_pkg::ST_LOAD) && head.valid && not_full;
	assign out_load = (state_q == ilms_pkg::ST_OUT_PUT) && (!out_valid_q || !result_stall);
	assign out_last = (idx_q + 1'b1 == cnt_q);

	assign ra = (state_q == ilms_pkg::ST_OUT_RD || state_q == ilms_pkg::ST_OUT_PUT) ?
			idx_q[AW-1:0] : a_q[AW-1:0];
	assign rb = b_q[AW-1:0];
	assign waddr = (state_q == ilms_pkg::ST_LOAD) ? cnt_q[AW-1:0] : p_q[AW-1:0];
	assign wdata = (state_q == ilms_pkg::ST_LOAD) ? head.item.key : (take_b ? db : da);
	assign we0 = load_wr || ((state_q == ilms_pkg::ST_MERGE_WR) && par_q);
	assign we1 = (state_q == ilms_pkg::ST_MERGE_WR) && !par_q;

	assign result_valid = out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			ilms_pkg::ST_LOAD: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.item.last_item) begin
						state_d = (cnt_q != '0) ? ilms_pkg::ST_RUN_INIT : ilms_pkg::ST_OUT_RD;
					end
				end
			end
			ilms_pkg::ST_RUN_INIT: state_d = ilms_pkg::ST_MERGE_RD;
			ilms_pkg::ST_MERGE_RD: state_d = ilms_pkg::ST_MERGE_WR;
			ilms_pkg::ST_MERGE_WR: begin
				if (sort_done) begin
					state_d = ilms_pkg::ST_OUT_RD;
				end else if (run_end) begin
					state_d = ilms_pkg::ST_RUN_INIT;
				end else begin
					state_d = ilms_pkg::ST_MERGE_RD;
				end
			end
			ilms_pkg::ST_OUT_RD: state_d = ilms_pkg::ST_OUT_PUT;
			ilms_pkg::ST_OUT_PUT: begin
				if (out_load) begin
					state_d = out_last ? ilms_pkg::ST_LOAD : ilms_pkg::ST_OUT_RD;
				end
			end
			default: state_d = ilms_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			drop_q <= 1'b0;
			par_q <= 1'b0;
			w_q <= '0;
			lo_q <= '0;
			a_q <= '0;
			b_q <= '0;
			p_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ilms_pkg::ST_LOAD: begin
					if (head.valid) begin
						if (not_full) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						par_q <= 1'b0;
						w_q <= CW'(1);
						lo_q <= '0;
						idx_q <= '0;
					end
				end
				ilms_pkg::ST_RUN_INIT: begin
					a_q <= lo_q;
					b_q <= mid;
					p_q <= lo_q;
				end
				ilms_pkg::ST_MERGE_WR: begin
					p_q <= p_q + 1'b1;
					if (take_b) begin
						b_q <= b_q + 1'b1;
					end else begin
						a_q <= a_q + 1'b1;
					end
					if (pass_end) begin
						lo_q <= '0;
						w_q <= w_next;
						par_q <= !par_q;
					end else if (run_end) begin
						lo_q <= hi;
					end
				end
				ilms_pkg::ST_OUT_PUT: begin
					if (out_load) begin
						idx_q <= idx_q + 1'b1;
						if (out_last) begin
							cnt_q <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sorted_key <= par_q ? rd1a_q : rd0a_q;
			out_q.last_result <= out_last;
			out_q.overflow <= drop_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[waddr] <= wdata;
		end
		rd0a_q <= mem0[ra];
		rd0b_q <= mem0[rb];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[waddr] <= wdata;
		end
		rd1a_q <= mem1[ra];
		rd1b_q <= mem1[rb];
	end

endmodule

/* hw/rtl/integer_list_merge_sorter_unit.sv */
// Top level of the integer list merge sorter.
// Depends on ilms_pkg, ilms_front and ilms_back.
//
// Keys enter at one item per cycle, unless item_stall shows the four-item queue
// full, and are written into the key memory as the sorter drains it; a list of
// n keys then takes ceil(log2 n) merge passes, in which each merge step reads
// the two run heads from a memory with registered read data and writes one key.
// The sorted keys leave through an output register, each read from the memory
// before it is loaded there. Keys beyond 64 in one list are dropped and every
// result of that list then shows overflow. The queue keeps taking items while
// the sorter is busy until it is full, and the next list may start loading while
// the last result of the previous one still waits to be taken.
module integer_list_merge_sorter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ilms_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ilms_pkg::result_t result
);

	ilms_pkg::queue_head_t head;
	logic pop;

	ilms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.pop        (pop)
	);

	ilms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* hw/rtl/ilms_checker.sv */
// Port checker of the integer list merge sorter, bound to the top level.
// Depends on ilms_pkg and integer_list_merge_sorter_unit.
module ilms_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input ilms_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input ilms_pkg::result_t result
);

	logic in_acc, out_acc;
	logic [2:0] lists_q;
	logic in_list_q;
	logic [ilms_pkg::KEY_WIDTH-1:0] prev_key_q;

	assign in_acc = item_valid && !item_stall;
	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_q <= '0;
			in_list_q <= 1'b0;
		end else begin
			if ((in_acc && item.last_item) && !(out_acc && result.last_result)) begin
				lists_q <= lists_q + 1'b1;
			end else if (!(in_acc && item.last_item) && (out_acc && result.last_result)) begin
				lists_q <= lists_q - 1'b1;
			end
			if (out_acc) begin
				in_list_q <= !result.last_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_key_q <= result.sorted_key;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_result_needs_list: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> lists_q != '0)
		else $error("result shown with no finished list pending");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && in_list_q |-> result.sorted_key >= prev_key_q)
		else $error("sorted keys out of order");

	a_overflow_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !result.last_result ##1 result_valid |->
		result.overflow == $past(result.overflow))
		else $error("overflow changed within one list");

endmodule

bind integer_list_merge_sorter_unit ilms_checker u_chk (.*);
